@@ design/ctli_pkg.sv @@
`default_nettype none

package ctli_pkg;

   // One requested color, packed red, green, blue from the high bits down.
   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } color_type;

   // Search transaction travelling down the row of cells.
   typedef struct packed {
      logic        valid;
      logic        found;
      logic [7:0]  index;
      color_type   color;
   } token_type;

   // One result as presented on the response channel.
   typedef struct packed {
      logic [7:0]  pixel_index;
      logic        was_present;
      logic        table_full;
   } result_type;

endpackage

`default_nettype wire

@@ design/color_table_lookup_insert.sv @@
// Colormap allocator with exact-match search.
//
// A request transaction on the req_ channel carries a 16-bit red, green and
// blue value. The block looks for an identical color among the filled table
// entries and answers on the rsp_ channel with that entry's index and
// rsp_was_present set. If no entry matches and the table has room, the color
// is stored in the next free entry and its index is returned. If the table
// is full, index 0 is returned with rsp_table_full set and nothing changes.
//
// The table is a row of TABLE_DEPTH cells, one entry each. A request passes
// one cell per clock, and the result leaving the last cell is registered.
// One request is in flight at a time; req_stall is high while it walks the
// row and while its result waits in the holding register, so a new request
// is taken only once the previous one has left the row.
//
// Reset empties the table (the fill count goes to zero) and drops any
// transaction in flight. A stalled response is held in the output register;
// the next request may still be accepted, and a second result waits in a
// holding register until the first one is taken.
`default_nettype none

module color_table_lookup_insert #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [15:0] req_red,
   input  wire logic [15:0] req_green,
   input  wire logic [15:0] req_blue,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_pixel_index,
   output      logic        rsp_was_present,
   output      logic        rsp_table_full
);
   import ctli_pkg::*;

   localparam int COUNT_WIDTH = $clog2(TABLE_DEPTH + 1);
   localparam logic [COUNT_WIDTH-1:0] DEPTH_COUNT = COUNT_WIDTH'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff, rsp_in;
   result_type              pend_ff, pend_in;
   result_type              finish_result;
   token_type               tokens [TABLE_DEPTH+1];
   logic                    req_accept;
   logic                    rsp_accept;
   logic                    finish;
   logic                    out_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   // Inject the accepted request at the head of the cell row.
   always_comb begin
      tokens[0].valid       = req_accept;
      tokens[0].found       = 1'b0;
      tokens[0].index       = 8'd0;
      tokens[0].color.red   = req_red;
      tokens[0].color.green = req_green;
      tokens[0].color.blue  = req_blue;
   end

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      ctli_cell #(
         .CELL_INDEX  (k),
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .entry_count (count_ff),
         .token_prev  (tokens[k]),
         .token_next  (tokens[k+1])
      );
   end

   // The transaction leaving the last cell carries the search outcome. On a
   // miss the insert already happened in the cell at the fill count.
   assign finish = tokens[TABLE_DEPTH].valid;

   always_comb begin
      finish_result.pixel_index = 8'd0;
      finish_result.was_present = 1'b0;
      finish_result.table_full  = 1'b0;
      if (tokens[TABLE_DEPTH].found) begin
         finish_result.pixel_index = tokens[TABLE_DEPTH].index;
         finish_result.was_present = 1'b1;
      end else if (count_ff < DEPTH_COUNT) begin
         finish_result.pixel_index = 8'(count_ff);
      end else begin
         finish_result.table_full = 1'b1;
      end
   end

   // The output register can take a new result if it is empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_accept;
      rsp_in       = rsp_ff;
      pend_in      = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (finish) begin
               if (!tokens[TABLE_DEPTH].found && (count_ff < DEPTH_COUNT)) begin
                  count_in = count_ff + 1'b1;
               end
               if (out_free) begin
                  rsp_in       = finish_result;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  pend_in  = finish_result;
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = rsp_ff.pixel_index;
   assign rsp_was_present = rsp_ff.was_present;
   assign rsp_table_full  = rsp_ff.table_full;

endmodule

`default_nettype wire

@@ design/ctli_cell.sv @@
`default_nettype none

module ctli_cell #(
   parameter int CELL_INDEX  = 0,
   parameter int COUNT_WIDTH = 9
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [COUNT_WIDTH-1:0] entry_count,
   input  wire ctli_pkg::token_type    token_prev,
   output      ctli_pkg::token_type    token_next
);
   import ctli_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CELL_POS = COUNT_WIDTH'(CELL_INDEX);
   localparam logic [7:0]             INDEX_LO = 8'(CELL_INDEX % 256);

   color_type entry_ff;
   token_type token_ff;
   token_type token_in;
   logic      hit;
   logic      write_here;

   // A filled cell compares; the first empty cell takes the color if nothing matched.
   assign hit        = token_prev.valid && !token_prev.found && (CELL_POS < entry_count)
                       && (entry_ff == token_prev.color);
   assign write_here = token_prev.valid && !token_prev.found && (CELL_POS == entry_count);

   always_comb begin
      token_in       = token_prev;
      token_in.found = token_prev.found | hit;
      if (hit) begin
         token_in.index = INDEX_LO;
      end
   end

   always_ff @(posedge clock) begin
      if (write_here) begin
         entry_ff <= token_prev.color;
      end
      if (reset) begin
         token_ff <= '0;
      end else begin
         token_ff <= token_in;
      end
   end

   assign token_next = token_ff;

endmodule

`default_nettype wire

@@ dv/palette_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the colormap allocator, keeps its own copy of the
// color table and compares every response with the oldest predicted one.
module palette_checker #(
   parameter int DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [15:0] req_red,
   input  wire logic [15:0] req_green,
   input  wire logic [15:0] req_blue,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [7:0]  rsp_pixel_index,
   input  wire logic        rsp_was_present,
   input  wire logic        rsp_table_full,
   output int               mismatch_count,
   output int               allocs_outstanding,
   output int               hit_count,
   output int               insert_count,
   output int               full_count
);
   import ctli_pkg::*;

   color_type  palette [DEPTH];
   int         palette_fill;
   result_type pending_allocs [$];
   int         errors;
   int         hits;
   int         inserts;
   int         fulls;

   initial begin
      palette_fill = 0;
      errors = 0;
      hits = 0;
      inserts = 0;
      fulls = 0;
   end

   // Exact-match search from index 0 up; append on a miss while there is room.
   function automatic result_type allocate_color(input color_type want);
      result_type res;
      bit         found;
      res = '0;
      found = 1'b0;
      for (int k = 0; k < palette_fill && !found; k++) begin
         if (palette[k] == want) begin
            found = 1'b1;
            res.pixel_index = k[7:0];
            res.was_present = 1'b1;
         end
      end
      if (found) begin
         hits++;
      end else if (palette_fill < DEPTH) begin
         palette[palette_fill] = want;
         res.pixel_index = palette_fill[7:0];
         palette_fill++;
         inserts++;
      end else begin
         res.table_full = 1'b1;
         fulls++;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want_rsp;
      if (reset) begin
         palette_fill = 0;
         pending_allocs.delete();
      end else begin
         if (req_valid && !req_stall) begin
            pending_allocs.push_back(allocate_color({req_red, req_green, req_blue}));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_allocs.size() == 0) begin
               $error("response with nothing expected: pixel_index %0d", rsp_pixel_index);
               errors++;
            end else begin
               want_rsp = pending_allocs.pop_front();
               if (rsp_pixel_index !== want_rsp.pixel_index) begin
                  $error("pixel_index: expected %0d, actual %0d",
                         want_rsp.pixel_index, rsp_pixel_index);
                  errors++;
               end
               if (rsp_was_present !== want_rsp.was_present) begin
                  $error("was_present: expected %0b, actual %0b",
                         want_rsp.was_present, rsp_was_present);
                  errors++;
               end
               if (rsp_table_full !== want_rsp.table_full) begin
                  $error("table_full: expected %0b, actual %0b",
                         want_rsp.table_full, rsp_table_full);
                  errors++;
               end
            end
         end
      end
      mismatch_count     <= errors;
      allocs_outstanding <= pending_allocs.size();
      hit_count          <= hits;
      insert_count       <= inserts;
      full_count         <= fulls;
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the colormap allocator. The palette_checker
// instance does all prediction and comparison; this module only makes
// request transactions, throttles the response channel and decides the end.
module tb_top;
   import ctli_pkg::*;

   localparam int TABLE_DEPTH = 256;
   // Random requests after the directed opening.
   localparam int N_RANDOM    = 880;
   // Random item at which the receiver starts its long hold-off.
   localparam int HOLD_AT     = 150;
   // Length of that hold-off in cycles.
   localparam int LONG_HOLD   = 1200;
   // Random item before which the sender waits for every response.
   localparam int DRAIN_AT    = 350;
   // From this random item on, neither side idles.
   localparam int QUIET_FROM  = 800;
   // Drain bound at the end, and the settle time after the last response.
   localparam int DRAIN_LIMIT = 20000;
   localparam int SETTLE      = 2 * (TABLE_DEPTH + 1);

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_red   = '0;
   logic [15:0] req_green = '0;
   logic [15:0] req_blue  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_pixel_index;
   logic        rsp_was_present;
   logic        rsp_table_full;

   int mismatch_count;
   int allocs_outstanding;
   int hit_count;
   int insert_count;
   int full_count;

   // Phase flags shared between the sender and the receiver process. They
   // are written with nonblocking assignments so both sides see them change
   // at the same edge.
   logic hold_go = 1'b0;
   logic quiet   = 1'b0;

   // Every color offered so far; repeats are drawn from here to make hits.
   color_type sent_colors [$];
   int        items_sent = 0;

   color_table_lookup_insert #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_index(rsp_pixel_index),
      .rsp_was_present(rsp_was_present),
      .rsp_table_full(rsp_table_full)
   );

   palette_checker #(
      .DEPTH(TABLE_DEPTH)
   ) u_palette_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_index(rsp_pixel_index),
      .rsp_was_present(rsp_was_present),
      .rsp_table_full(rsp_table_full),
      .mismatch_count(mismatch_count),
      .allocs_outstanding(allocs_outstanding),
      .hit_count(hit_count),
      .insert_count(insert_count),
      .full_count(full_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Offers one request transaction and returns at the edge that accepts it.
   // An optional idle burst comes first. When there is none, valid simply
   // stays high and the payload moves on to the new color in the same step.
   task automatic offer_color(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sent_colors.push_back({r, g, b});
      items_sent++;
   endtask

   // Builds a color that is usually new: fully random, a one-bit neighbor of
   // a color already sent (the compare must see every bit), or a mix of
   // all-zero, all-one and random fields.
   function automatic color_type fresh_color(input int kind);
      color_type c;
      int        flip;
      c.red   = 16'($urandom);
      c.green = 16'($urandom);
      c.blue  = 16'($urandom);
      if (kind == 1 && sent_colors.size() > 0) begin
         c = sent_colors[$urandom_range(0, sent_colors.size() - 1)];
         flip = $urandom_range(0, 47);
         c[flip] = ~c[flip];
      end else if (kind == 2) begin
         case ($urandom_range(0, 2))
            0: c.red = 16'h0000;
            1: c.red = 16'hFFFF;
            default: ;
         endcase
         case ($urandom_range(0, 2))
            0: c.green = 16'h0000;
            1: c.green = 16'hFFFF;
            default: ;
         endcase
         case ($urandom_range(0, 2))
            0: c.blue = 16'h0000;
            1: c.blue = 16'hFFFF;
            default: ;
         endcase
      end
      return c;
   endfunction

   // Receiver: random stall bursts, one long hold-off when
   // the sender asks for it, and no stalls at all in the quiet tail.
   initial begin
      int burst;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (hold_go) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_go   <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 6);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Sender and verdict.
   initial begin
      color_type c;
      int        pick;
      int        drain_cycles;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening. The all-zero and all-one colors, single-channel
      // extremes, one-bit neighbors of stored colors, and repeats that must
      // hit the first entry and a later one.
      offer_color(16'h0000, 16'h0000, 16'h0000);
      offer_color(16'hFFFF, 16'hFFFF, 16'hFFFF);
      offer_color(16'h0000, 16'h0000, 16'h0000);
      offer_color(16'hFFFF, 16'h0000, 16'h0000);
      offer_color(16'h0000, 16'hFFFF, 16'h0000);
      offer_color(16'h0000, 16'h0000, 16'hFFFF);
      offer_color(16'hFFFF, 16'hFFFF, 16'hFFFE);
      offer_color(16'h0001, 16'h0000, 16'h0000);
      offer_color(16'h0000, 16'h0000, 16'h0001);
      offer_color(16'h7FFF, 16'hFFFF, 16'hFFFF);
      offer_color(16'hFFFF, 16'hFFFF, 16'hFFFF);
      offer_color(16'hFFFF, 16'h0000, 16'h0000);
      offer_color(16'hAAAA, 16'h5555, 16'hAAAA);
      offer_color(16'h5555, 16'hAAAA, 16'h5555);
      offer_color(16'hAAAA, 16'h5555, 16'hAAAA);
      offer_color(16'h0000, 16'h0000, 16'h0001);
      offer_color(16'h8000, 16'h8000, 16'h8000);
      offer_color(16'h0000, 16'h0000, 16'h0000);

      // Random part. About half the requests repeat a color already sent,
      // so hits land on early, middle and late entries. The other half are
      // new, which fills all entries partway through the run; after that
      // the new colors must come back with the table full, while repeats
      // of stored colors still hit.
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == HOLD_AT) begin
            // The receiver holds off while requests keep coming, so the
            // block's output and holding registers fill and req_stall stays
            // high until the hold ends.
            hold_go <= 1'b1;
         end
         if (i == DRAIN_AT) begin
            // Pause until every response has come, so the next request meets
            // a fully idle block.
            req_valid <= 1'b0;
            do @(posedge clock); while (allocs_outstanding != 0);
         end
         if (i == QUIET_FROM) begin
            quiet <= 1'b1;
         end
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            c = sent_colors[$urandom_range(0, sent_colors.size() - 1)];
         end else if (pick < 7) begin
            c = fresh_color(0);
         end else if (pick < 8) begin
            c = fresh_color(1);
         end else begin
            c = fresh_color(2);
         end
         offer_color(c.red, c.green, c.blue);
      end
      req_valid <= 1'b0;

      // Wait for the last responses, bounded, then let the block settle.
      drain_cycles = 0;
      do begin
         @(posedge clock);
         drain_cycles++;
      end while (allocs_outstanding != 0 && drain_cycles < DRAIN_LIMIT);
      repeat (SETTLE) @(posedge clock);

      $display("Sent %0d requests: %0d matched a stored color, %0d added an entry,",
               items_sent, hit_count, insert_count);
      $display("%0d met a full table; one %0d-cycle response hold-off and one full drain.",
               full_count, LONG_HOLD);
      if (mismatch_count == 0 && allocs_outstanding == 0) begin
         $display("** color_table_lookup_insert: PASSED **");
      end else begin
         $display("** color_table_lookup_insert: FAILED **");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #8_000_000;
      $display("** color_table_lookup_insert: FAILED **");
      $finish;
   end

endmodule

@@ files.f @@
design/ctli_pkg.sv
design/ctli_cell.sv
design/color_table_lookup_insert.sv
dv/palette_checker.sv
dv/tb_top.sv
